// ===== sv/sha256_stream_hasher_top_defines.svh =====
// Assertion macros for the SHA-256 stream hasher
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH
// assert that a implies b on the next clock edge
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
// assert that a implies b on the same clock edge
`define SHA_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`endif

// ===== sv/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions
package sha_pkg;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_req;

    function automatic logic [31:0] f_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[idx];
    endfunction

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ===== sv/sha_queue.sv =====
// Request queue between the front end and the block engine
module sha_queue
    import sha_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_req o_req
);
    localparam int Aw = $clog2(Depth);
    t_req r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(push) - (Aw+1)'(pop);
        end
    end
endmodule

// ===== sv/sha_engine.sv =====
// Block engine: byte buffer, padding, 64-round compression, digest output
module sha_engine
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_ROUND = 3'd2,
                           S_ADD = 3'd3, S_OUT = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [511:0] r_blk;
    logic [5:0]   r_cnt;
    logic [63:0]  r_bits;
    logic [255:0] r_h, r_v;
    logic [511:0] r_w;      // 16-word schedule window, word 0 in top bits
    logic [5:0]   r_rnd;
    logic         r_fin;    // compression belongs to the final padding
    logic         r_two;    // a further padding block is still needed
    logic [2:0]   r_oidx;
    logic         r_ovalid;

    logic [511:0] pad_blk;
    logic [31:0]  a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn, x, y;
    logic         take;

    assign take    = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // padding: 0x80 at the fill position, zeros after, length if room
    always_comb begin
        pad_blk = r_blk;
        for (int i = 0; i < 64; i++) begin
            if (6'(i) == r_cnt) begin
                pad_blk[511-8*i -: 8] = PadByte;
            end else if (6'(i) > r_cnt) begin
                pad_blk[511-8*i -: 8] = 8'h00;
            end
        end
        if (r_cnt < LenPos) begin
            pad_blk[63:0] = r_bits;
        end
    end

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        w0 = r_w[511:480];
        t1 = h + (f_rotr(e, 6) ^ f_rotr(e, 11) ^ f_rotr(e, 25))
               + ((e & f) ^ (~e & g)) + f_k(r_rnd) + w0;
        t2 = (f_rotr(a, 2) ^ f_rotr(a, 13) ^ f_rotr(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
        x  = r_w[479:448];
        y  = r_w[63:32];
        s0 = f_rotr(x, 7) ^ f_rotr(x, 18) ^ (x >> 3);
        s1 = f_rotr(y, 17) ^ f_rotr(y, 19) ^ (y >> 10);
        wn = s1 + r_w[223:192] + s0 + w0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_req.byte_present && r_cnt == 6'd63) begin
                        n_state = S_ROUND;
                    end else if (i_req.end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD:   n_state = S_ROUND;
            S_ROUND: n_state = (r_rnd == 6'd63) ? S_ADD : S_ROUND;
            S_ADD: begin
                if (!r_fin) begin
                    // full block done: pad an empty block if an end request closed it
                    n_state = r_two ? S_PAD : S_IDLE;
                end else if (r_two) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (r_ovalid && !i_stall && r_oidx == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_bits   <= '0;
            r_h      <= InitHash;
            r_fin    <= 1'b0;
            r_two    <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
            r_rnd    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (take && i_req.byte_present) begin
                        r_blk[511-8*r_cnt -: 8] <= i_req.data_byte;
                        r_cnt  <= r_cnt + 1'b1;
                        r_bits <= r_bits + 64'd8;
                        if (r_cnt == 6'd63) begin
                            r_w <= {r_blk[511:8], i_req.data_byte};
                            r_v <= r_h;
                            r_rnd <= '0;
                            r_fin <= 1'b0;
                        end
                    end
                    if (take) begin
                        r_two <= i_req.end_of_message;  // end pending after a full block
                    end
                end
                S_PAD: begin
                    r_w   <= pad_blk;
                    r_v   <= r_h;
                    r_rnd <= '0;
                    r_fin <= 1'b1;
                    r_two <= (r_cnt >= LenPos);
                    r_blk <= {448'h0, r_bits};
                end
                S_ROUND: begin
                    r_v   <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    r_w   <= {r_w[479:0], wn};
                    r_rnd <= r_rnd + 1'b1;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[255-32*i -: 32] <= r_h[255-32*i -: 32] + r_v[255-32*i -: 32];
                    end
                    if (r_fin && r_two) begin
                        r_w   <= r_blk;
                        r_v   <= {r_h[255:224] + r_v[255:224], r_h[223:192] + r_v[223:192],
                                  r_h[191:160] + r_v[191:160], r_h[159:128] + r_v[159:128],
                                  r_h[127:96] + r_v[127:96], r_h[95:64] + r_v[95:64],
                                  r_h[63:32] + r_v[63:32], r_h[31:0] + r_v[31:0]};
                        r_rnd <= '0;
                        r_two <= 1'b0;
                    end else if (r_fin) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                    end else if (r_two) begin
                        r_two <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_h      <= InitHash;
                            r_cnt    <= '0;
                            r_bits   <= '0;
                            r_fin    <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_h[255-32*r_oidx -: 32];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);
endmodule

// ===== sv/sha256_stream_hasher_top.sv =====
// A byte that fills a block holds the engine through the rounds and the final add; an end
// request passes the registered queue, then padding, rounds and add, with a further compression
// when the padding needs a block of its own. Bytes go in one per cycle while the engine is idle.
// A four-deep request queue decouples input from the engine; digest words one per cycle while i_stall is low.
// Reset (synchronous, active low) restores initial hash, counts and queue.
// Top level: SHA-256 stream hasher
module sha256_stream_hasher_top
    import sha_pkg::*;
#(
    parameter int QDepth = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
`include "sha256_stream_hasher_top_defines.svh"
    t_req in_req, q_req;
    logic q_valid, q_stall;

    assign in_req = '{data_byte: i_data_byte, byte_present: i_byte_present,
                      end_of_message: i_end_of_message};

    sha_queue #(.Depth(QDepth)) u_queue (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req(in_req),
        .o_valid(q_valid), .i_stall(q_stall), .o_req(q_req));

    sha_engine u_engine (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_req(q_req),
        .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word);

    `SHA_ASSERT_SAME(a_last_idx, i_clk, i_rst_n, o_valid && o_last_word, o_word_index == 3'd7, "last word index")
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_word_index), "digest word dropped")
    `SHA_ASSERT_SAME(a_busy, i_clk, i_rst_n, o_valid, q_stall, "engine took request while emitting")
endmodule
